/* rtl/grid_maze_dfs_path_core_macros.svh */
// Assertion macros for the maze solver core.
`ifndef GRID_MAZE_DFS_PATH_CORE_MACROS_SVH
`define GRID_MAZE_DFS_PATH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gmd_pkg.sv */
// Shared types and constants for the grid maze DFS solver.
package gmd_pkg;

  localparam int unsigned MaxRows = 32;
  localparam int unsigned MaxCols = 32;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned IdxW    = RowW + ColW;
  localparam int unsigned Cells   = MaxRows * MaxCols;
  localparam int unsigned DepthW  = $clog2(Cells + 1);
  localparam int unsigned DirW    = 3;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StackW  = IdxW + DirW;

  // command codes
  localparam logic [CmdW-1:0] CmdLoad  = 2'd0;
  localparam logic [CmdW-1:0] CmdSolve = 2'd1;
  localparam logic [CmdW-1:0] CmdRead  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgGridRows = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgGridCols = 8'd1;

  // cell characters
  localparam logic [CharW-1:0] ChOpen  = 8'h5F;
  localparam logic [CharW-1:0] ChPath  = 8'h2E;
  localparam logic [CharW-1:0] ChDead  = 8'h78;
  localparam logic [CharW-1:0] ChStart = 8'h49;
  localparam logic [CharW-1:0] ChEnd   = 8'h46;

  // search directions, probed in this order
  localparam logic [DirW-1:0] DirLeft  = 3'd0;
  localparam logic [DirW-1:0] DirUp    = 3'd1;
  localparam logic [DirW-1:0] DirRight = 3'd2;
  localparam logic [DirW-1:0] DirDown  = 3'd3;
  localparam logic [DirW-1:0] DirDone  = 3'd4;

  localparam logic [CfgW-1:0] RowsReset = 6'd32;
  localparam logic [CfgW-1:0] ColsReset = 6'd32;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [CharW-1:0] cell_char;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] read_char;
    logic             path_found;
  } out_item_t;

  typedef enum logic [3:0] {
    DpNop,
    DpLoad,
    DpRead,
    DpStartRd,
    DpStartMark,
    DpStartPush,
    DpStep,
    DpPush,
    DpPop,
    DpPopLoad,
    DpSweep
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic start_oob;
    logic start_is_end;
    logic rdata_open;
    logic dir_done;
    logic nbr_oob;
    logic nbr_is_end;
    logic depth_one;
    logic sweep_last;
  } dp_status_t;

endpackage

/* rtl/gmd_dpath.sv */
// Datapath: grid memory, search stack memory, search registers and cleanup sweep.
module gmd_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gmd_pkg::dp_cmd_t                 cmd_i,
  input  gmd_pkg::in_item_t                item_i,
  input  logic                             cfg_valid_i,
  input  logic [gmd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gmd_pkg::CfgW-1:0]         cfg_data_i,
  output gmd_pkg::dp_status_t              status_o,
  output logic [gmd_pkg::CharW-1:0]        grid_rdata_o
);

  logic [gmd_pkg::CharW-1:0]  grid_mem [gmd_pkg::Cells];
  logic [gmd_pkg::StackW-1:0] stack_mem [gmd_pkg::Cells];

  logic [gmd_pkg::CharW-1:0]  grid_rdata_q;
  logic [gmd_pkg::StackW-1:0] stack_rdata_q;

  logic [gmd_pkg::CfgW-1:0]   rows_q, cols_q;
  logic [gmd_pkg::IdxW-1:0]   start_q, end_q;
  logic [gmd_pkg::IdxW-1:0]   top_idx_q, nbr_q, sweep_wr_q;
  logic [gmd_pkg::DirW-1:0]   top_dir_q;
  logic [gmd_pkg::DepthW-1:0] depth_q, sweep_q;
  logic                       sweep_vld_q;

  logic [gmd_pkg::RowW-1:0]   top_row, start_row, sw_row;
  logic [gmd_pkg::ColW-1:0]   top_col, start_col, sw_col;
  logic [gmd_pkg::CfgW-1:0]   nbr_row, nbr_col;
  logic                       nbr_under, nbr_oob, nbr_is_end;
  logic [gmd_pkg::IdxW-1:0]   nbr_idx, in_idx;
  logic [gmd_pkg::CharW-1:0]  load_char;
  logic [gmd_pkg::DepthW-1:0] depth_m1, depth_m2;
  logic                       sweep_rd, sweep_wr;
  logic                       in_is_start, in_is_end;

  logic                       g_we, g_re;
  logic [gmd_pkg::IdxW-1:0]   g_waddr, g_raddr;
  logic [gmd_pkg::CharW-1:0]  g_wdata;
  logic                       s_we, s_re;
  logic [gmd_pkg::IdxW-1:0]   s_waddr, s_raddr;

  assign top_row   = top_idx_q[gmd_pkg::IdxW-1:gmd_pkg::ColW];
  assign top_col   = top_idx_q[gmd_pkg::ColW-1:0];
  assign start_row = start_q[gmd_pkg::IdxW-1:gmd_pkg::ColW];
  assign start_col = start_q[gmd_pkg::ColW-1:0];
  assign sw_row    = sweep_wr_q[gmd_pkg::IdxW-1:gmd_pkg::ColW];
  assign sw_col    = sweep_wr_q[gmd_pkg::ColW-1:0];
  assign in_idx    = {item_i.row, item_i.col};
  assign depth_m1  = depth_q - gmd_pkg::DepthW'(1);
  assign depth_m2  = depth_q - gmd_pkg::DepthW'(2);

  always_comb begin
    nbr_row   = gmd_pkg::CfgW'(top_row);
    nbr_col   = gmd_pkg::CfgW'(top_col);
    nbr_under = 1'b0;
    unique case (top_dir_q)
      gmd_pkg::DirLeft: begin
        nbr_col   = gmd_pkg::CfgW'(top_col) - gmd_pkg::CfgW'(1);
        nbr_under = (top_col == '0);
      end
      gmd_pkg::DirUp: begin
        nbr_row   = gmd_pkg::CfgW'(top_row) - gmd_pkg::CfgW'(1);
        nbr_under = (top_row == '0);
      end
      gmd_pkg::DirRight: nbr_col = gmd_pkg::CfgW'(top_col) + gmd_pkg::CfgW'(1);
      gmd_pkg::DirDown:  nbr_row = gmd_pkg::CfgW'(top_row) + gmd_pkg::CfgW'(1);
      default: ;
    endcase
  end

  assign nbr_idx    = {nbr_row[gmd_pkg::RowW-1:0], nbr_col[gmd_pkg::ColW-1:0]};
  // register values above the grid size clamp to it
  assign nbr_oob    = nbr_under || (nbr_row >= rows_q) || (nbr_col >= cols_q) ||
                      (nbr_row >= gmd_pkg::CfgW'(gmd_pkg::MaxRows)) ||
                      (nbr_col >= gmd_pkg::CfgW'(gmd_pkg::MaxCols));
  assign nbr_is_end = (nbr_idx == end_q);

  assign in_is_start = (item_i.cell_char == gmd_pkg::ChStart);
  assign in_is_end   = (item_i.cell_char == gmd_pkg::ChEnd);
  assign load_char   = (in_is_start || in_is_end) ? gmd_pkg::ChOpen : item_i.cell_char;

  // sweep: read one cell per cycle, write back '_' over 'x' in the next cycle
  assign sweep_rd = (sweep_q != gmd_pkg::DepthW'(gmd_pkg::Cells));
  assign sweep_wr = sweep_vld_q && (grid_rdata_q == gmd_pkg::ChDead) &&
                    (gmd_pkg::CfgW'(sw_row) < rows_q) && (gmd_pkg::CfgW'(sw_col) < cols_q);

  always_comb begin
    g_we    = 1'b0;
    g_re    = 1'b0;
    g_waddr = nbr_q;
    g_raddr = nbr_idx;
    g_wdata = gmd_pkg::ChPath;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = depth_m1[gmd_pkg::IdxW-1:0];
    s_raddr = depth_m2[gmd_pkg::IdxW-1:0];
    unique case (cmd_i.op)
      gmd_pkg::DpLoad: begin
        g_we    = 1'b1;
        g_waddr = in_idx;
        g_wdata = load_char;
      end
      gmd_pkg::DpRead: begin
        g_re    = 1'b1;
        g_raddr = in_idx;
      end
      gmd_pkg::DpStartRd: begin
        g_re    = 1'b1;
        g_raddr = start_q;
      end
      gmd_pkg::DpStartMark, gmd_pkg::DpStartPush: begin
        g_we    = 1'b1;
        g_waddr = start_q;
      end
      gmd_pkg::DpStep: begin
        if (!nbr_oob) begin
          g_we    = nbr_is_end;
          g_re    = !nbr_is_end;
          g_waddr = nbr_idx;
        end
      end
      gmd_pkg::DpPush: begin
        g_we = 1'b1;
        s_we = 1'b1;
      end
      gmd_pkg::DpPop: begin
        g_we    = 1'b1;
        g_waddr = top_idx_q;
        g_wdata = gmd_pkg::ChDead;
        s_re    = (depth_q != gmd_pkg::DepthW'(1));
      end
      gmd_pkg::DpSweep: begin
        g_re    = sweep_rd;
        g_raddr = sweep_q[gmd_pkg::IdxW-1:0];
        g_we    = sweep_wr;
        g_waddr = sweep_wr_q;
        g_wdata = gmd_pkg::ChOpen;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      grid_rdata_q <= grid_mem[g_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      stack_mem[s_waddr] <= {top_idx_q, top_dir_q};
    end
    if (s_re) begin
      stack_rdata_q <= stack_mem[s_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= gmd_pkg::RowsReset;
      cols_q      <= gmd_pkg::ColsReset;
      start_q     <= '0;
      end_q       <= '0;
      top_idx_q   <= '0;
      top_dir_q   <= gmd_pkg::DirLeft;
      nbr_q       <= '0;
      depth_q     <= '0;
      sweep_q     <= '0;
      sweep_vld_q <= 1'b0;
      sweep_wr_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == gmd_pkg::CfgGridRows) begin
          rows_q <= cfg_data_i;
        end else if (cfg_index_i == gmd_pkg::CfgGridCols) begin
          cols_q <= cfg_data_i;
        end
      end
      sweep_q     <= '0;
      sweep_vld_q <= 1'b0;
      unique case (cmd_i.op)
        gmd_pkg::DpLoad: begin
          if (in_is_start) begin
            start_q <= in_idx;
          end else if (in_is_end) begin
            end_q <= in_idx;
          end
        end
        gmd_pkg::DpStartPush: begin
          top_idx_q <= start_q;
          top_dir_q <= gmd_pkg::DirLeft;
          depth_q   <= gmd_pkg::DepthW'(1);
        end
        gmd_pkg::DpStep: begin
          top_dir_q <= top_dir_q + gmd_pkg::DirW'(1);
          nbr_q     <= nbr_idx;
        end
        gmd_pkg::DpPush: begin
          top_idx_q <= nbr_q;
          top_dir_q <= gmd_pkg::DirLeft;
          depth_q   <= depth_q + gmd_pkg::DepthW'(1);
        end
        gmd_pkg::DpPop: depth_q <= depth_m1;
        gmd_pkg::DpPopLoad: begin
          top_idx_q <= stack_rdata_q[gmd_pkg::StackW-1:gmd_pkg::DirW];
          top_dir_q <= stack_rdata_q[gmd_pkg::DirW-1:0];
        end
        gmd_pkg::DpSweep: begin
          depth_q     <= '0;
          sweep_vld_q <= sweep_rd;
          sweep_wr_q  <= sweep_q[gmd_pkg::IdxW-1:0];
          if (sweep_rd) begin
            sweep_q <= sweep_q + gmd_pkg::DepthW'(1);
          end else begin
            sweep_q <= sweep_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.start_oob    = (gmd_pkg::CfgW'(start_row) >= rows_q) ||
                                 (gmd_pkg::CfgW'(start_col) >= cols_q);
  assign status_o.start_is_end = (start_q == end_q);
  assign status_o.rdata_open   = (grid_rdata_q == gmd_pkg::ChOpen);
  assign status_o.dir_done     = (top_dir_q >= gmd_pkg::DirDone);
  assign status_o.nbr_oob      = nbr_oob;
  assign status_o.nbr_is_end   = nbr_is_end;
  assign status_o.depth_one    = (depth_q == gmd_pkg::DepthW'(1));
  assign status_o.sweep_last   = !sweep_rd;

  assign grid_rdata_o = grid_rdata_q;

endmodule

/* rtl/gmd_ctrl.sv */
// Controller: command dispatch, search sequencing and result register.
module gmd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [gmd_pkg::CmdW-1:0]   in_cmd_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_read_o,
  output logic                       out_found_o,
  output logic                       busy_o,
  input  gmd_pkg::dp_status_t        status_i,
  output gmd_pkg::dp_cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StStartChk,
    StTop,
    StNbr,
    StPopWait,
    StClean
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_read_q, out_read_d;
  logic   out_found_q, out_found_d;
  logic   found_q, found_d;
  logic   out_set;
  logic   accept;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    out_set     = 1'b0;
    out_read_d  = out_read_q;
    out_found_d = out_found_q;
    cmd_o.op    = gmd_pkg::DpNop;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_cmd_i)
            gmd_pkg::CmdLoad: begin
              cmd_o.op    = gmd_pkg::DpLoad;
              out_set     = 1'b1;
              out_read_d  = 1'b0;
              out_found_d = 1'b0;
            end
            gmd_pkg::CmdRead: begin
              cmd_o.op    = gmd_pkg::DpRead;
              out_set     = 1'b1;
              out_read_d  = 1'b1;
              out_found_d = 1'b0;
            end
            gmd_pkg::CmdSolve: begin
              state_d = StStart;
              found_d = 1'b0;
            end
            default: begin
              out_set     = 1'b1;
              out_read_d  = 1'b0;
              out_found_d = 1'b0;
            end
          endcase
        end
      end
      StStart: begin
        priority if (status_i.start_oob) begin
          state_d = StClean;
        end else if (status_i.start_is_end) begin
          cmd_o.op = gmd_pkg::DpStartMark;
          found_d  = 1'b1;
          state_d  = StClean;
        end else begin
          cmd_o.op = gmd_pkg::DpStartRd;
          state_d  = StStartChk;
        end
      end
      StStartChk: begin
        if (status_i.rdata_open) begin
          cmd_o.op = gmd_pkg::DpStartPush;
          state_d  = StTop;
        end else begin
          state_d = StClean;
        end
      end
      StTop: begin
        if (status_i.dir_done) begin
          // all four neighbors tried: dead end, backtrack
          cmd_o.op = gmd_pkg::DpPop;
          state_d  = status_i.depth_one ? StClean : StPopWait;
        end else begin
          cmd_o.op = gmd_pkg::DpStep;
          priority if (status_i.nbr_oob) begin
            state_d = StTop;
          end else if (status_i.nbr_is_end) begin
            found_d = 1'b1;
            state_d = StClean;
          end else begin
            state_d = StNbr;
          end
        end
      end
      StNbr: begin
        if (status_i.rdata_open) begin
          cmd_o.op = gmd_pkg::DpPush;
        end
        state_d = StTop;
      end
      StPopWait: begin
        cmd_o.op = gmd_pkg::DpPopLoad;
        state_d  = StTop;
      end
      StClean: begin
        cmd_o.op = gmd_pkg::DpSweep;
        if (status_i.sweep_last) begin
          state_d     = StIdle;
          out_set     = 1'b1;
          out_read_d  = 1'b0;
          out_found_d = found_q;
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_set || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_read_q  <= 1'b0;
      out_found_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_read_q  <= out_read_d;
      out_found_q <= out_found_d;
      found_q     <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_read_o  = out_read_q;
  assign out_found_o = out_found_q;
  assign busy_o      = (state_q != StIdle);

endmodule

/* rtl/grid_maze_dfs_path_core.sv */
// Top level of the grid maze solver: depth-first search over a 32x32 cell store.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i        | item in
//  out     | out_valid_o, out_stall_i, out_data_o     | result out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | register write
//          | cfg_data_i                               |
//
// Load, read and unknown commands may follow every cycle while no result waits stalled.
// A solve checks and enters the start cell, probes each neighbor in turn (reading it
// unless it is off grid or the end), pops a stack entry on each backtrack, then runs a
// cleanup sweep over every grid cell; the input stalls throughout.
// Reset: rows and columns 32, start and end cell 0; grid and stack contents undefined.
// The input also stalls while a result waits under out_stall_i.
`include "grid_maze_dfs_path_core_macros.svh"

module grid_maze_dfs_path_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gmd_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gmd_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gmd_pkg::CfgW-1:0]     cfg_data_i
);

  gmd_pkg::dp_cmd_t            dp_cmd;
  gmd_pkg::dp_status_t         dp_status;
  logic [gmd_pkg::CharW-1:0]   grid_rdata;
  logic                        out_read, out_found, busy;

  assign cfg_ready_o = 1'b1;

  gmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_read_o  (out_read),
    .out_found_o (out_found),
    .busy_o      (busy),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  gmd_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .item_i       (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .status_o     (dp_status),
    .grid_rdata_o (grid_rdata)
  );

  // read data comes straight from the grid memory's output register
  assign out_data_o.read_char  = out_read ? grid_rdata : '0;
  assign out_data_o.path_found = out_found;

  `GMD_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, in_valid_i && !in_stall_o, busy || out_valid_o, "accepted transfer left no work or result")
  `GMD_ASSERT_IMPL(a_solve_result, clk_i, rst_ni, $fell(busy), out_valid_o, "solve finished without a result")
  `GMD_ASSERT_IMPL(a_found_no_char, clk_i, rst_ni, out_valid_o && out_data_o.path_found, out_data_o.read_char == '0, "solve result carries read data")

endmodule
